// File: src/vrs_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and elaboration-time CORDIC tables for vertex_rotate_scale.
package vrs_pkg;

	// field and register widths
	localparam int COORD_WIDTH_DEF = 16;
	localparam int COORD_FRAC      = 8;
	localparam int ANGLE_W         = 16;
	localparam int QTR_BITS        = 14;
	localparam int SCALE_W         = 16;
	localparam int SCALE_FRAC      = 8;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ROTATION_ANGLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR   = 1'd1;

	localparam logic [ANGLE_W-1:0] ANGLE_RESET = 16'd0;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

	// Q1.14 trig values, held as 16-bit signed
	localparam int TRIG_FRAC = 14;
	localparam int TRIG_W    = 16;

	// CORDIC chain: x/y carry 44 fraction bits, z is in quarter turns with 46 fraction bits
	localparam int CORDIC_STAGES = 44;
	localparam int XY_FRAC       = 44;
	localparam int XY_W          = XY_FRAC + 2;
	localparam int Z_FRAC        = 46;
	localparam int Z_W           = Z_FRAC + 2;

	localparam real TWO_OVER_PI = 0.63661977236758134308;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} cordic_vec_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] cos;
		logic signed [TRIG_W-1:0] sin;
	} trig_t;

	// atan(2^-i) in quarter turns, Z_FRAC fraction bits
	function automatic logic signed [Z_W-1:0] atan_const(input int i);
		real    a;
		longint v;
		a = $atan(2.0 ** (-i)) * TWO_OVER_PI * (2.0 ** Z_FRAC);
		v = longint'(a);
		return v[Z_W-1:0];
	endfunction

	// 1/K of the whole chain, XY_FRAC fraction bits, used as the start vector
	function automatic logic signed [XY_W-1:0] cordic_gain_inv();
		real    k;
		longint v;
		int     i;
		k = 1.0;
		for (i = 0; i < CORDIC_STAGES; i++) begin
			k = k * $cos($atan(2.0 ** (-i)));
		end
		v = longint'(k * (2.0 ** XY_FRAC));
		return v[XY_W-1:0];
	endfunction

endpackage

// File: src/vertex_rotate_scale.sv
`timescale 1ns / 1ps
// Vertex rotation and scale: Q8.8 vertices rotated by a set angle and scaled, saturating.
// Each vertex passes the registered stages s1, s2, s3 and s4 before its result is presented.
// Throughput: one vertex per cycle while the input is not stalled; a stalled output holds only the stages behind it.
// cos/sin come from a 44-cell CORDIC chain; after reset and after every rotation_angle
// write the input is stalled while the new angle walks through the cells.
// Reset: asynchronous, active low; clears registers to angle 0 and scale 1.0.
module vertex_rotate_scale import vrs_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] vertex_x,
	input  logic signed [COORD_WIDTH-1:0] vertex_y,
	input  logic                          last_vertex,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic                          saturated,
	output logic                          out_last
);

	localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
	localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(64'd1 << TRIG_FRAC);

	logic [ANGLE_W-1:0] rotation_angle_q;
	logic [SCALE_W-1:0] scale_factor_q;
	logic               cfg_wr;
	logic               angle_wr;
	trig_t              trig;
	logic               trig_busy;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign angle_wr  = cfg_wr && (cfg_index == REG_ROTATION_ANGLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_angle_q <= ANGLE_RESET;
			scale_factor_q   <= SCALE_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_ROTATION_ANGLE: rotation_angle_q <= cfg_data[ANGLE_W-1:0];
				REG_SCALE_FACTOR:   scale_factor_q   <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	vrs_trig_gen u_trig (
		.clk       (clk),
		.arst_n    (arst_n),
		.angle     (rotation_angle_q),
		.angle_load(angle_wr),
		.trig      (trig),
		.busy      (trig_busy)
	);

	vrs_xform #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_xform (
		.clk        (clk),
		.arst_n     (arst_n),
		.hold       (trig_busy),
		.trig       (trig),
		.scale      (scale_factor_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.vertex_x   (vertex_x),
		.vertex_y   (vertex_y),
		.last_vertex(last_vertex),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_x      (out_x),
		.out_y      (out_y),
		.saturated  (saturated),
		.out_last   (out_last)
	);

`ifndef ASSERT_OFF
	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		trig_busy |-> in_stall)
		else $error("vertex transaction possible while trig chain settles");

	a_angle_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		angle_wr |=> trig_busy)
		else $error("angle write did not restart trig settle");

	a_trig_range: assert property (@(posedge clk) disable iff (!arst_n)
		!trig_busy |-> (trig.cos <= TRIG_ONE && trig.cos >= -TRIG_ONE &&
			trig.sin <= TRIG_ONE && trig.sin >= -TRIG_ONE))
		else $error("trig value out of Q1.14 unit range");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |-> (out_x == COORD_MAX || out_x == COORD_MIN ||
			out_y == COORD_MAX || out_y == COORD_MIN))
		else $error("saturation flag without a coordinate at its limit");
`endif

endmodule

// File: src/vrs_cordic_cell.sv
`timescale 1ns / 1ps
// One CORDIC rotation micro-step with its output register.
module vrs_cordic_cell import vrs_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic        clk,
	input  cordic_vec_t vec_in,
	output cordic_vec_t vec_out
);

	localparam logic signed [Z_W-1:0] ATAN = atan_const(STAGE);

	cordic_vec_t vec_q;

	always_ff @(posedge clk) begin
		if (!vec_in.z[Z_W-1]) begin
			vec_q.x <= vec_in.x - (vec_in.y >>> STAGE);
			vec_q.y <= vec_in.y + (vec_in.x >>> STAGE);
			vec_q.z <= vec_in.z - ATAN;
		end else begin
			vec_q.x <= vec_in.x + (vec_in.y >>> STAGE);
			vec_q.y <= vec_in.y - (vec_in.x >>> STAGE);
			vec_q.z <= vec_in.z + ATAN;
		end
	end

	assign vec_out = vec_q;

endmodule

// File: src/vrs_trig_gen.sv
`timescale 1ns / 1ps
// Cosine/sine generator: CORDIC cell chain, Q1.14 rounding, quadrant fold, settle counter.
module vrs_trig_gen import vrs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [ANGLE_W-1:0] angle,
	input  logic               angle_load,
	output trig_t              trig,
	output logic               busy
);

	localparam int SETTLE = CORDIC_STAGES + 1;
	localparam int CNT_W  = $clog2(SETTLE + 1);
	localparam int RND_SH = XY_FRAC - TRIG_FRAC;
	localparam logic signed [XY_W-1:0] RND_HALF = XY_W'(64'd1 << (RND_SH - 1));

	cordic_vec_t chain [CORDIC_STAGES+1];

	logic [1:0]              quad;
	logic [QTR_BITS-1:0]     resid;
	logic signed [XY_W-1:0]  cos_rnd;
	logic signed [XY_W-1:0]  sin_rnd;
	logic signed [XY_W-1:0]  cos_sh;
	logic signed [XY_W-1:0]  sin_sh;
	logic signed [TRIG_W-1:0] c0;
	logic signed [TRIG_W-1:0] s0;
	trig_t                   trig_d;
	trig_t                   trig_q;
	logic [CNT_W-1:0]        cnt_q;

	assign quad  = angle[ANGLE_W-1 -: 2];
	assign resid = angle[QTR_BITS-1:0];

	// start vector (1/K, 0), residual angle in quarter turns
	assign chain[0].x = cordic_gain_inv();
	assign chain[0].y = '0;
	assign chain[0].z = Z_W'({resid, {(Z_FRAC - QTR_BITS){1'b0}}});

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		vrs_cordic_cell #(
			.STAGE(g)
		) u_cell (
			.clk    (clk),
			.vec_in (chain[g]),
			.vec_out(chain[g+1])
		);
	end

	// round to nearest, ties up
	assign cos_rnd = chain[CORDIC_STAGES].x + RND_HALF;
	assign sin_rnd = chain[CORDIC_STAGES].y + RND_HALF;
	assign cos_sh  = cos_rnd >>> RND_SH;
	assign sin_sh  = sin_rnd >>> RND_SH;
	assign c0      = cos_sh[TRIG_W-1:0];
	assign s0      = sin_sh[TRIG_W-1:0];

	always_comb begin
		unique case (quad)
			2'd0: begin
				trig_d.sin = s0;
				trig_d.cos = c0;
			end
			2'd1: begin
				trig_d.sin = c0;
				trig_d.cos = -s0;
			end
			2'd2: begin
				trig_d.sin = -s0;
				trig_d.cos = -c0;
			end
			default: begin
				trig_d.sin = -c0;
				trig_d.cos = s0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		trig_q <= trig_d;
	end

	// chain output is stale until a new angle has walked through every cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_W'(SETTLE);
		end else if (angle_load) begin
			cnt_q <= CNT_W'(SETTLE);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign trig = trig_q;
	assign busy = (cnt_q != '0);

endmodule

// File: src/vrs_xform.sv
`timescale 1ns / 1ps
// Vertex datapath: rotate products, Q8.8 rounding, scale, round and saturate, with flow control.
module vrs_xform import vrs_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          hold,
	input  trig_t                         trig,
	input  logic [SCALE_W-1:0]            scale,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] vertex_x,
	input  logic signed [COORD_WIDTH-1:0] vertex_y,
	input  logic                          last_vertex,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic                          saturated,
	output logic                          out_last
);

	localparam int CW = COORD_WIDTH;
	localparam int PW = CW + TRIG_W;
	localparam int SW = PW + 1;
	localparam int RW = SW - TRIG_FRAC;
	localparam int MW = RW + SCALE_W + 1;
	localparam logic signed [SW-1:0] HALF_ROT = SW'(64'd1 << (TRIG_FRAC - 1));
	localparam logic signed [MW-1:0] HALF_SCL = MW'(64'd1 << (SCALE_FRAC - 1));
	localparam logic signed [MW-1:0] MAX_V = {{(MW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
	localparam logic signed [MW-1:0] MIN_V = {{(MW - CW + 1){1'b1}}, {(CW - 1){1'b0}}};

	logic rdy1, rdy2, rdy3, rdy4;
	logic v1_s1, v2_s2, v3_s3, v4_s4;

	logic signed [PW-1:0] xc_s1, ys_s1, xs_s1, yc_s1;
	logic                 last_s1;
	logic signed [SW-1:0] sum_x, sum_y;
	logic signed [SW-1:0] sum_x_sh, sum_y_sh;
	logic signed [RW-1:0] rx_s2, ry_s2;
	logic                 last_s2;
	logic signed [MW-1:0] px_s3, py_s3;
	logic                 last_s3;
	logic signed [MW-1:0] rnd_x, rnd_y;
	logic signed [MW-1:0] sh_x, sh_y;
	logic [CW:0]          clip_x, clip_y;
	logic signed [CW-1:0] x_s4, y_s4;
	logic                 sat_s4, last_s4;

	// {flag, value}
	function automatic logic [CW:0] clip_coord(input logic signed [MW-1:0] v);
		logic [CW:0] r;
		if (v > MAX_V) begin
			r = {1'b1, MAX_V[CW-1:0]};
		end else if (v < MIN_V) begin
			r = {1'b1, MIN_V[CW-1:0]};
		end else begin
			r = {1'b0, v[CW-1:0]};
		end
		return r;
	endfunction

	// a stage takes new data when it is empty or its content moves on
	assign rdy4     = !v4_s4 || !out_stall;
	assign rdy3     = !v3_s3 || rdy4;
	assign rdy2     = !v2_s2 || rdy3;
	assign rdy1     = !v1_s1 || rdy2;
	assign in_stall = hold || !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				v1_s1 <= in_valid && !hold;
			end
			if (rdy2) begin
				v2_s2 <= v1_s1;
			end
			if (rdy3) begin
				v3_s3 <= v2_s2;
			end
			if (rdy4) begin
				v4_s4 <= v3_s3;
			end
		end
	end

	assign sum_x    = SW'(xc_s1) - SW'(ys_s1) + HALF_ROT;
	assign sum_y    = SW'(xs_s1) + SW'(yc_s1) + HALF_ROT;
	assign sum_x_sh = sum_x >>> TRIG_FRAC;
	assign sum_y_sh = sum_y >>> TRIG_FRAC;

	assign rnd_x  = px_s3 + HALF_SCL;
	assign rnd_y  = py_s3 + HALF_SCL;
	assign sh_x   = rnd_x >>> SCALE_FRAC;
	assign sh_y   = rnd_y >>> SCALE_FRAC;
	assign clip_x = clip_coord(sh_x);
	assign clip_y = clip_coord(sh_y);

	always_ff @(posedge clk) begin
		if (rdy1) begin
			xc_s1   <= PW'(vertex_x) * PW'(trig.cos);
			ys_s1   <= PW'(vertex_y) * PW'(trig.sin);
			xs_s1   <= PW'(vertex_x) * PW'(trig.sin);
			yc_s1   <= PW'(vertex_y) * PW'(trig.cos);
			last_s1 <= last_vertex;
		end
		if (rdy2) begin
			rx_s2   <= sum_x_sh[RW-1:0];
			ry_s2   <= sum_y_sh[RW-1:0];
			last_s2 <= last_s1;
		end
		if (rdy3) begin
			px_s3   <= MW'(rx_s2) * MW'($signed({1'b0, scale}));
			py_s3   <= MW'(ry_s2) * MW'($signed({1'b0, scale}));
			last_s3 <= last_s2;
		end
		if (rdy4) begin
			x_s4    <= clip_x[CW-1:0];
			y_s4    <= clip_y[CW-1:0];
			sat_s4  <= clip_x[CW] | clip_y[CW];
			last_s4 <= last_s3;
		end
	end

	assign out_valid = v4_s4;
	assign out_x     = x_s4;
	assign out_y     = y_s4;
	assign saturated = sat_s4;
	assign out_last  = last_s4;

endmodule
